// ----- hw/rtl/psc_pkg.sv -----
// psc_pkg: shared types and constants of the stepper speed controller
// used by psc_ctrl, psc_datapath and pid_stepper_speed_control
`default_nettype none

package psc_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EST,
    S_MEAS,
    S_INT,
    S_MUL,
    S_DIV,
    S_FIX,
    S_TICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic est;
    logic meas;
    logic integ;
    logic mul;
    logic div;
    logic fix;
    logic tick;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 8'd3;

  localparam logic [8:0] TARGET_RESET = 9'd0;
  localparam logic [7:0] GAIN_P_RESET = 8'd5;
  localparam logic [7:0] GAIN_I_RESET = 8'd0;
  localparam logic [7:0] GAIN_D_RESET = 8'd0;

  localparam logic        OP_SAMPLE = 1'b0;
  localparam logic        OP_TICK   = 1'b1;

  localparam int SPEED_W     = 9;
  localparam int TICK_W      = 7;
  localparam int ACC_W       = 25;
  localparam int INTEG_LIMIT = 1000;
  localparam int SPEED_SCALE = 500;
  localparam int RAW_FULL    = 255;
  localparam int RECIP_255   = 257;
  localparam int DRIVE_DIV   = 100;
  localparam int RECIP_100   = 655;

  localparam logic [3:0] COIL_RESET = 4'h3;
  localparam logic [3:0] COIL_OFF   = 4'h0;

  localparam logic [3:0] HALF_STEP [8] = '{
    4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9, 4'h1, 4'h3
  };

endpackage

`default_nettype wire

// ----- hw/rtl/psc_ctrl.sv -----
// psc_ctrl: sequencer of the stepper speed controller
// depends on psc_pkg for state, command and status types
`default_nettype none

module psc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  input  wire logic            op,
  output logic                 s_tready,
  input  wire psc_pkg::status_t status,
  output psc_pkg::cmd_t        cmd
);

  psc_pkg::state_t state;
  psc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      psc_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = (op == psc_pkg::OP_TICK) ? psc_pkg::S_TICK : psc_pkg::S_EST;
        end
      end
      psc_pkg::S_EST:  state_next = psc_pkg::S_MEAS;
      psc_pkg::S_MEAS: state_next = psc_pkg::S_INT;
      psc_pkg::S_INT:  state_next = psc_pkg::S_MUL;
      psc_pkg::S_MUL:  state_next = psc_pkg::S_DIV;
      psc_pkg::S_DIV:  state_next = psc_pkg::S_FIX;
      psc_pkg::S_FIX:  state_next = psc_pkg::S_DONE;
      psc_pkg::S_TICK: state_next = psc_pkg::S_DONE;
      psc_pkg::S_DONE: begin
        if (status.out_free) begin
          state_next = psc_pkg::S_IDLE;
        end
      end
      default: state_next = psc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      psc_pkg::S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      psc_pkg::S_EST:  cmd.est   = 1'b1;
      psc_pkg::S_MEAS: cmd.meas  = 1'b1;
      psc_pkg::S_INT:  cmd.integ = 1'b1;
      psc_pkg::S_MUL:  cmd.mul   = 1'b1;
      psc_pkg::S_DIV:  cmd.div   = 1'b1;
      psc_pkg::S_FIX:  cmd.fix   = 1'b1;
      psc_pkg::S_TICK: cmd.tick  = 1'b1;
      psc_pkg::S_DONE: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/psc_datapath.sv -----
// psc_datapath: speed scaling, pid arithmetic, step timing and result register
// depends on psc_pkg; driven by commands from psc_ctrl
`default_nettype none

module psc_datapath #(
  parameter  int PHASE_COUNT = 8,
  parameter  int DRIVE_MAX   = 100,
  localparam int DW          = $clog2(DRIVE_MAX + 1),
  localparam int PH_W        = $clog2(PHASE_COUNT),
  localparam int OUT_BITS    = 4 + DW + psc_pkg::SPEED_W + 1,
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire psc_pkg::cmd_t                   cmd,
  output psc_pkg::status_t                     status,
  input  wire logic [7:0]                      sample,
  input  wire logic                            cfg_valid,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [OUT_W-1:0]                     m_tdata
);

  localparam int BOUND = psc_pkg::DRIVE_DIV * (DRIVE_MAX + 1);

  logic [8:0] target;
  logic [7:0] gain_p;
  logic [7:0] gain_i;
  logic [7:0] gain_d;

  logic [16:0]                    v_q;
  logic [8:0]                     qs_q;
  logic [psc_pkg::SPEED_W-1:0]    measured;
  logic signed [10:0]             integ;
  logic signed [9:0]              prev_err;
  logic signed [9:0]              err_q;
  logic signed [10:0]             deriv_q;
  logic signed [psc_pkg::ACC_W-1:0] acc_q;
  logic [14:0]                    a_q;
  logic [8:0]                     qe_q;
  logic                           sat_q;
  logic [DW-1:0]                  drive;
  logic [psc_pkg::TICK_W-1:0]     tick_cnt;
  logic [PH_W-1:0]                phase;
  logic [3:0]                     coil;
  logic                           stepped_q;

  logic [24:0]                    est_prod;
  logic [16:0]                    meas_rem;
  logic [8:0]                     meas_next;
  logic signed [10:0]             err_w;
  logic signed [11:0]             isum;
  logic signed [10:0]             integ_next;
  logic signed [8:0]              gp_s;
  logic signed [8:0]              gi_s;
  logic signed [8:0]              gd_s;
  logic signed [18:0]             prod_p;
  logic signed [19:0]             prod_i;
  logic signed [19:0]             prod_d;
  logic signed [psc_pkg::ACC_W-1:0] term_p;
  logic signed [psc_pkg::ACC_W-1:0] term_i;
  logic signed [psc_pkg::ACC_W-1:0] term_d;
  logic signed [psc_pkg::ACC_W-1:0] acc_next;
  logic [14:0]                    a_next;
  logic [24:0]                    div_prod;
  logic [14:0]                    div_rem;
  logic [8:0]                     quot;
  logic [psc_pkg::TICK_W-1:0]     tick_inc;
  logic [14:0]                    tick_prod;
  logic [PH_W:0]                  phase_inc;
  logic [PH_W-1:0]                phase_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= psc_pkg::TARGET_RESET;
      gain_p <= psc_pkg::GAIN_P_RESET;
      gain_i <= psc_pkg::GAIN_I_RESET;
      gain_d <= psc_pkg::GAIN_D_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        psc_pkg::REG_TARGET: target <= cfg_data[8:0];
        psc_pkg::REG_GAIN_P: gain_p <= cfg_data[7:0];
        psc_pkg::REG_GAIN_I: gain_i <= cfg_data[7:0];
        psc_pkg::REG_GAIN_D: gain_d <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // speed scaling: estimate by reciprocal, then one correction
  assign est_prod  = 25'(v_q) + {v_q, 8'b0};
  assign meas_rem  = v_q - 17'(qs_q) * 17'(psc_pkg::RAW_FULL);
  assign meas_next = (meas_rem >= 17'(psc_pkg::RAW_FULL)) ? qs_q + 9'd1 : qs_q;

  // error, clamped integral and derivative
  assign err_w = $signed({2'b00, target}) - $signed({2'b00, measured});
  assign isum  = 12'(integ) + 12'(err_w);
  always_comb begin
    if (isum > 12'sd1000) begin
      integ_next = 11'(psc_pkg::INTEG_LIMIT);
    end else if (isum < -12'sd1000) begin
      integ_next = -11'(psc_pkg::INTEG_LIMIT);
    end else begin
      integ_next = 11'(isum);
    end
  end

  // weighted sum
  assign gp_s   = $signed({1'b0, gain_p});
  assign gi_s   = $signed({1'b0, gain_i});
  assign gd_s   = $signed({1'b0, gain_d});
  assign prod_p = 19'(gp_s) * 19'(err_q);
  assign prod_i = 20'(gi_s) * 20'(integ);
  assign prod_d = 20'(gd_s) * 20'(deriv_q);
  assign term_p = psc_pkg::ACC_W'(prod_p);
  assign term_i = psc_pkg::ACC_W'(prod_i);
  assign term_d = psc_pkg::ACC_W'(prod_d);
  assign acc_next = (term_p <<< 3) + (term_p <<< 1)
                  + (term_i <<< 1) + term_i
                  + (term_d <<< 3) + (term_d <<< 1);

  // divide by one hundred: reciprocal estimate, then one correction
  assign a_next   = (acc_q > 0) ? acc_q[14:0] : '0;
  assign div_prod = 25'(a_next) * 25'(psc_pkg::RECIP_100);
  assign div_rem  = a_q - 15'(qe_q) * 15'(psc_pkg::DRIVE_DIV);
  assign quot     = (div_rem >= 15'(psc_pkg::DRIVE_DIV)) ? qe_q + 9'd1 : qe_q;

  // step timing: count reaches DRIVE_MAX/drive + 1 exactly when count*drive > DRIVE_MAX
  assign tick_inc   = (tick_cnt == '1) ? tick_cnt : tick_cnt + 1'b1;
  assign tick_prod  = 15'(tick_inc) * 15'(drive);
  assign phase_inc  = (PH_W + 1)'(phase) + 1'b1;
  assign phase_next = (phase_inc < (PH_W + 1)'(PHASE_COUNT)) ? phase_inc[PH_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v_q <= 17'(sample) * 17'(psc_pkg::SPEED_SCALE);
    end
    if (cmd.est) begin
      qs_q <= est_prod[24:16];
    end
    if (cmd.mul) begin
      acc_q <= acc_next;
    end
    if (cmd.integ) begin
      err_q   <= 10'(err_w);
      deriv_q <= err_w - 11'(prev_err);
    end
    if (cmd.div) begin
      sat_q <= (acc_q >= psc_pkg::ACC_W'(BOUND));
      a_q   <= a_next;
      qe_q  <= div_prod[24:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measured  <= '0;
      integ     <= '0;
      prev_err  <= '0;
      drive     <= '0;
      tick_cnt  <= '0;
      phase     <= '0;
      coil      <= psc_pkg::COIL_RESET;
      stepped_q <= 1'b0;
    end else begin
      if (cmd.capture) begin
        stepped_q <= 1'b0;
      end
      if (cmd.meas) begin
        measured <= meas_next;
      end
      if (cmd.integ) begin
        integ    <= integ_next;
        prev_err <= 10'(err_w);
      end
      if (cmd.fix) begin
        drive <= sat_q ? DW'(DRIVE_MAX) : DW'(quot);
      end
      if (cmd.tick) begin
        if (drive == '0) begin
          coil     <= psc_pkg::COIL_OFF;
          tick_cnt <= '0;
        end else if (tick_prod > 15'(DRIVE_MAX)) begin
          tick_cnt  <= '0;
          phase     <= phase_next;
          coil      <= psc_pkg::HALF_STEP[3'(phase_next)];
          stepped_q <= 1'b1;
        end else begin
          tick_cnt <= tick_inc;
        end
      end
    end
  end

  // result register
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= OUT_W'({stepped_q, measured, drive, coil});
    end
  end

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    drive <= DW'(DRIVE_MAX))
    else $error("drive above limit");

  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    (integ <= 11'sd1000) && (integ >= -11'sd1000))
    else $error("integral outside clamp");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("result not presented after load");

  a_zero_drive_off: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick && (drive == '0)) |=> (coil == psc_pkg::COIL_OFF) && !stepped_q)
    else $error("coils energised with zero drive");

endmodule

`default_nettype wire

// ----- hw/rtl/pid_stepper_speed_control.sv -----
// pid_stepper_speed_control: pid speed controller for a half-step stepper drive
// top level; instantiates psc_ctrl and psc_datapath, types from psc_pkg
//
// input channel s_*: s_tuser is the operation (0 speed sample, 1 timer tick),
// s_tdata carries the raw 8-bit speed reading. every request gives exactly one
// result on m_*: coil pattern, drive level, scaled speed and a stepped flag.
// configuration channel cfg_*: cfg_index selects target speed, p, i or d gain;
// cfg_ready is always high, unknown indexes are dropped. write only when idle.
// the controller walks a sample through the scaling, error and integral, pid
// sum and divide-by-100 steps one per cycle in the shared datapath, and a tick
// through the step timing; a new request is taken only once the last result
// has been loaded into the output register.
// a new drive value takes effect at the next tick.
// reset: gains to defaults, integral, drive and phase to zero, coils to the
// pattern 4'h3. if the receiver stalls, the result is held in the
// output register; one more request is taken and worked through, then the
// block waits in its last step and takes nothing further until the held
// result is taken.
`default_nettype none

module pid_stepper_speed_control #(
  parameter  int PHASE_COUNT = 8,
  parameter  int DRIVE_MAX   = 100,
  localparam int DW          = $clog2(DRIVE_MAX + 1),
  localparam int OUT_BITS    = 4 + DW + psc_pkg::SPEED_W + 1,
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // sample
  input  wire logic                            s_tuser,   // op
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [OUT_W-1:0]                     m_tdata,   // coil_pattern, drive_level,
                                                          // scaled_speed, stepped
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  psc_pkg::cmd_t    cmd;
  psc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  psc_datapath #(
    .PHASE_COUNT (PHASE_COUNT),
    .DRIVE_MAX   (DRIVE_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
